>>> rtl/efsd_pkg.sv
// efsd_pkg: shared types and constants for the earliest-free server dispatch block
// no dependencies; used by the interfaces, the sequencer and the top level

package efsd_pkg;

  // fixed field widths
  localparam int FUNC_W  = 1;
  localparam int SIDX_W  = 6;
  localparam int SVC_W   = 16;
  localparam int TIME_W  = 48;
  localparam int JOB_W   = 48;
  localparam int CFG_W   = 7;

  // input function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD     = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_UPDATE,
    ST_HOLD
  } efsd_state_t;

  // result handed from the sequencer to the output stage
  typedef struct packed {
    logic              valid;
    logic [SIDX_W-1:0] chosen;
    logic [TIME_W-1:0] start;
  } efsd_res_t;

endpackage

>>> rtl/efsd_if.sv
// efsd channel interfaces: input items, result items and the configuration write
// depends on efsd_pkg for field widths

interface efsd_in_if;
  logic                         valid;
  logic                         ready;
  logic [efsd_pkg::FUNC_W-1:0]  func;
  logic [efsd_pkg::SIDX_W-1:0]  server_index;
  logic [efsd_pkg::SVC_W-1:0]   service_time;

  modport source (output valid, func, server_index, service_time, input ready);
  modport sink   (input valid, func, server_index, service_time, output ready);
endinterface

interface efsd_out_if;
  logic                         valid;
  logic                         ready;
  logic [efsd_pkg::SIDX_W-1:0]  chosen_server;
  logic [efsd_pkg::TIME_W-1:0]  start_time;
  logic [efsd_pkg::JOB_W-1:0]   job_number;

  modport source (output valid, chosen_server, start_time, job_number, input ready);
  modport sink   (input valid, chosen_server, start_time, job_number, output ready);
endinterface

interface efsd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [efsd_pkg::CFG_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/earliest_free_server_dispatch_top.sv
// earliest_free_server_dispatch_top: top level of the earliest-free server dispatch block
// depends on efsd_pkg, efsd_if, efsd_seq (and through it efsd_store)
//
// Usage:
//   in_ch carries one transaction per item: func 0 loads service_time into
//   server_index and clears that server's next-free time (no result); func 1
//   dispatches one job and yields one transaction on out_ch with the chosen
//   server, its start time and the running job number.
//   cfg_ch writes servers_in_use (0 is taken as 1, values above MAX_SERVERS
//   as MAX_SERVERS); write it only while the block is idle.
// Timing:
//   a load is written in the cycle it is accepted. A dispatch keeps in_ch not
//   ready while it scans the N servers in use, one next-free time per cycle
//   through the single read port of the server memory, and while it fetches and
//   updates the chosen entry, until its result is taken into the output register.
// Reset: rst_n (synchronous, active low) sets all next-free times to zero,
//   all service times to one, the job count to zero and servers_in_use to 1.
// Stall: the output register holds its result while out_ch is not ready; a
//   following dispatch finishes its scan and then waits for the register.

module earliest_free_server_dispatch_top #(
  parameter int MAX_SERVERS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  efsd_in_if.sink    in_ch,
  efsd_out_if.source out_ch,
  efsd_cfg_if.sink   cfg_ch
);

  localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CW = $clog2(MAX_SERVERS + 1);

  logic [efsd_pkg::CFG_W-1:0]  servers_r;
  logic [CW-1:0]               count;
  logic                        idle;
  logic                        in_acc;
  efsd_pkg::efsd_res_t         res;
  logic                        res_taken;

  logic                        out_valid_r;
  logic [efsd_pkg::SIDX_W-1:0] out_chosen_r;
  logic [efsd_pkg::TIME_W-1:0] out_start_r;
  logic [efsd_pkg::JOB_W-1:0]  jobs_r;

  // configuration register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servers_r <= efsd_pkg::CFG_W'(1);
    end else if (cfg_ch.valid) begin
      servers_r <= cfg_ch.data;
    end
  end

  // clamp to the pool size
  always_comb begin
    if (servers_r == '0) begin
      count = CW'(1);
    end else if (int'(servers_r) > MAX_SERVERS) begin
      count = CW'(MAX_SERVERS);
    end else begin
      count = CW'(servers_r);
    end
  end

  // input transaction
  assign in_ch.ready = idle;
  assign in_acc      = in_ch.valid && idle;

  efsd_seq #(
    .MAX_SERVERS (MAX_SERVERS),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_load (in_acc && (in_ch.func == efsd_pkg::FUNC_LOAD)),
    .start_disp (in_acc && (in_ch.func == efsd_pkg::FUNC_DISPATCH)),
    .ld_idx     (in_ch.server_index),
    .ld_svc     (in_ch.service_time),
    .count      (count),
    .idle       (idle),
    .res        (res),
    .res_taken  (res_taken)
  );

  // output register and job counter
  assign res_taken = res.valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      jobs_r      <= '0;
    end else begin
      if (res_taken) begin
        out_valid_r <= 1'b1;
        jobs_r      <= jobs_r + efsd_pkg::JOB_W'(1);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      out_chosen_r <= res.chosen;
      out_start_r  <= res.start;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.chosen_server = out_chosen_r;
  assign out_ch.start_time    = out_start_r;
  assign out_ch.job_number    = jobs_r;

endmodule

>>> rtl/efsd_store.sv
// efsd_store: per-server next-free time and service time memories
// one write and one registered read a cycle; valid bits give the reset values
// depends on efsd_pkg

module efsd_store #(
  parameter int MAX_SERVERS = 64,
  parameter int AW          = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [AW-1:0]                 rd_addr,
  output logic [efsd_pkg::TIME_W-1:0]   rd_nft,
  output logic [efsd_pkg::SVC_W-1:0]    rd_svc,
  input  logic                          wr_nft_en,
  input  logic                          wr_svc_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [efsd_pkg::TIME_W-1:0]   wr_nft,
  input  logic [efsd_pkg::SVC_W-1:0]    wr_svc
);

  logic [efsd_pkg::TIME_W-1:0] nft_mem [MAX_SERVERS];
  logic [efsd_pkg::SVC_W-1:0]  svc_mem [MAX_SERVERS];

  logic [MAX_SERVERS-1:0]      nft_vld_r;
  logic [MAX_SERVERS-1:0]      svc_vld_r;
  logic [efsd_pkg::TIME_W-1:0] nft_raw_r;
  logic [efsd_pkg::SVC_W-1:0]  svc_raw_r;
  logic                        nft_hit_r;
  logic                        svc_hit_r;

  // memory writes
  always_ff @(posedge clk) begin
    if (wr_nft_en) begin
      nft_mem[wr_addr] <= wr_nft;
    end
    if (wr_svc_en) begin
      svc_mem[wr_addr] <= wr_svc;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    nft_raw_r <= nft_mem[rd_addr];
    svc_raw_r <= svc_mem[rd_addr];
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nft_vld_r <= '0;
      svc_vld_r <= '0;
      nft_hit_r <= 1'b0;
      svc_hit_r <= 1'b0;
    end else begin
      if (wr_nft_en) begin
        nft_vld_r[wr_addr] <= 1'b1;
      end
      if (wr_svc_en) begin
        svc_vld_r[wr_addr] <= 1'b1;
      end
      nft_hit_r <= nft_vld_r[rd_addr];
      svc_hit_r <= svc_vld_r[rd_addr];
    end
  end

  // unwritten entries read as their reset values
  assign rd_nft = nft_hit_r ? nft_raw_r : '0;
  assign rd_svc = svc_hit_r ? svc_raw_r : efsd_pkg::SVC_W'(1);

endmodule

>>> rtl/efsd_seq.sv
// efsd_seq: sequencer with one shared compare and add unit
// scans the next-free times one server a cycle, then updates the chosen entry
// depends on efsd_pkg and efsd_store

module efsd_seq #(
  parameter int MAX_SERVERS = 64,
  parameter int AW          = 6,
  parameter int CW          = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_load,
  input  logic                          start_disp,
  input  logic [efsd_pkg::SIDX_W-1:0]   ld_idx,
  input  logic [efsd_pkg::SVC_W-1:0]    ld_svc,
  input  logic [CW-1:0]                 count,
  output logic                          idle,
  output efsd_pkg::efsd_res_t           res,
  input  logic                          res_taken
);

  efsd_pkg::efsd_state_t       state_r, state_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [AW-1:0]               best_idx_r, best_idx_nxt;
  logic [efsd_pkg::TIME_W-1:0] best_val_r, best_val_nxt;

  logic [AW-1:0]               rd_addr;
  logic [efsd_pkg::TIME_W-1:0] rd_nft;
  logic [efsd_pkg::SVC_W-1:0]  rd_svc;
  logic                        wr_nft_en;
  logic                        wr_svc_en;
  logic [AW-1:0]               wr_addr;
  logic [efsd_pkg::TIME_W-1:0] wr_nft;
  logic [efsd_pkg::SVC_W-1:0]  wr_svc;

  logic                        ld_in_pool;
  logic                        take;
  logic [efsd_pkg::TIME_W:0]   sum;
  logic [efsd_pkg::TIME_W-1:0] sum_sat;

  efsd_store #(
    .MAX_SERVERS (MAX_SERVERS),
    .AW          (AW)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr   (rd_addr),
    .rd_nft    (rd_nft),
    .rd_svc    (rd_svc),
    .wr_nft_en (wr_nft_en),
    .wr_svc_en (wr_svc_en),
    .wr_addr   (wr_addr),
    .wr_nft    (wr_nft),
    .wr_svc    (wr_svc)
  );

  // shared unit: compare for the scan, saturating add for the update
  assign take    = (cnt_r == CW'(1)) || (rd_nft < best_val_r);
  assign sum     = {1'b0, best_val_r} + {{(efsd_pkg::TIME_W+1-efsd_pkg::SVC_W){1'b0}}, rd_svc};
  assign sum_sat = sum[efsd_pkg::TIME_W] ? '1 : sum[efsd_pkg::TIME_W-1:0];

  assign ld_in_pool = (int'(ld_idx) < MAX_SERVERS);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      efsd_pkg::ST_IDLE: begin
        if (start_disp) begin
          state_nxt = efsd_pkg::ST_SCAN;
        end
      end
      efsd_pkg::ST_SCAN: begin
        if (cnt_r == count) begin
          state_nxt = efsd_pkg::ST_FETCH;
        end
      end
      efsd_pkg::ST_FETCH:  state_nxt = efsd_pkg::ST_UPDATE;
      efsd_pkg::ST_UPDATE: state_nxt = efsd_pkg::ST_HOLD;
      efsd_pkg::ST_HOLD: begin
        if (res_taken) begin
          state_nxt = efsd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = efsd_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    idle         = 1'b0;
    cnt_nxt      = cnt_r;
    best_idx_nxt = best_idx_r;
    best_val_nxt = best_val_r;
    rd_addr      = '0;
    wr_nft_en    = 1'b0;
    wr_svc_en    = 1'b0;
    wr_addr      = best_idx_r;
    wr_nft       = sum_sat;
    wr_svc       = ld_svc;
    unique case (state_r)
      efsd_pkg::ST_IDLE: begin
        idle    = 1'b1;
        cnt_nxt = '0;
        // load: write service time, clear next-free time
        if (start_load && ld_in_pool) begin
          wr_nft_en = 1'b1;
          wr_svc_en = 1'b1;
          wr_addr   = AW'(ld_idx);
          wr_nft    = '0;
        end
      end
      efsd_pkg::ST_SCAN: begin
        if (cnt_r < count) begin
          rd_addr = cnt_r[AW-1:0];
        end
        // data for server cnt_r-1 arrives this cycle
        if (cnt_r != '0 && take) begin
          best_idx_nxt = AW'(cnt_r - CW'(1));
          best_val_nxt = rd_nft;
        end
        cnt_nxt = cnt_r + CW'(1);
      end
      efsd_pkg::ST_FETCH: begin
        rd_addr = best_idx_r;
      end
      efsd_pkg::ST_UPDATE: begin
        wr_nft_en = 1'b1;
      end
      efsd_pkg::ST_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  assign res.valid  = (state_r == efsd_pkg::ST_HOLD);
  assign res.chosen = efsd_pkg::SIDX_W'(best_idx_r);
  assign res.start  = best_val_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= efsd_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // scan result registers
  always_ff @(posedge clk) begin
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
  end

endmodule

>>> bench/earliest_free_server_dispatch_top_tb.sv
`timescale 1ns / 100ps
// testbench for earliest_free_server_dispatch_top: directed then random load/dispatch traffic,
// checked against an in-bench scheduler model; depends on efsd_pkg, efsd_if and the rtl

module earliest_free_server_dispatch_top_tb;

  localparam int MAX_SERVERS   = 64;
  localparam int SETTLE_CYCLES = MAX_SERVERS + 16;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_ITEMS   = 75;

  typedef struct packed {
    logic [efsd_pkg::FUNC_W-1:0] func;
    logic [efsd_pkg::SIDX_W-1:0] sidx;
    logic [efsd_pkg::SVC_W-1:0]  svc;
    logic                        drain;
  } job_req_t;

  typedef struct packed {
    logic [efsd_pkg::SIDX_W-1:0] server;
    logic [efsd_pkg::TIME_W-1:0] start;
    logic [efsd_pkg::JOB_W-1:0]  job;
  } grant_t;

  logic clk;
  logic rst_n;

  efsd_in_if  in_ch ();
  efsd_out_if out_ch ();
  efsd_cfg_if cfg_ch ();

  earliest_free_server_dispatch_top #(
    .MAX_SERVERS(MAX_SERVERS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // scheduler model state
  logic [efsd_pkg::TIME_W-1:0] free_at  [MAX_SERVERS];
  logic [efsd_pkg::SVC_W-1:0]  busy_for [MAX_SERVERS];
  logic [efsd_pkg::JOB_W-1:0]  jobs_issued;
  logic [efsd_pkg::CFG_W-1:0]  pool_size;

  job_req_t job_req_q [$];
  grant_t   grant_q   [$];

  int  fail_count    = 0;
  bit  idle_on       = 1'b0;
  int  hold_requests = 0;
  int  hold_served   = 0;

  // driver / monitor working variables
  job_req_t cur_req;
  bit       take_in;
  bit       offer;
  int       send_gap;
  int       stall_left;
  bit       ready_next;
  grant_t   want;

  logic [efsd_pkg::CFG_W-1:0] pool_plan [12];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // servers taking part for the current pool setting
  function automatic int active_span();
    if (pool_size == '0) return 1;
    if (int'(pool_size) > MAX_SERVERS) return MAX_SERVERS;
    return int'(pool_size);
  endfunction

  // model one accepted transaction; a dispatch queues its grant
  task automatic schedule_job(input job_req_t r);
    int                        span;
    int                        best;
    logic [efsd_pkg::TIME_W:0] sum;
    grant_t                    g;
    if (r.func == efsd_pkg::FUNC_LOAD) begin
      if (int'(r.sidx) < MAX_SERVERS) begin
        busy_for[r.sidx] = r.svc;
        free_at[r.sidx]  = '0;
      end
    end else begin
      span = active_span();
      best = 0;
      for (int i = 1; i < span; i++) begin
        if (free_at[i] < free_at[best]) best = i;
      end
      sum         = {1'b0, free_at[best]} + {{(efsd_pkg::TIME_W+1-efsd_pkg::SVC_W){1'b0}},
                                             busy_for[best]};
      jobs_issued = jobs_issued + efsd_pkg::JOB_W'(1);
      g.server    = efsd_pkg::SIDX_W'(best);
      g.start     = free_at[best];
      g.job       = jobs_issued;
      // saturate the next-free time
      free_at[best] = sum[efsd_pkg::TIME_W] ? '1 : sum[efsd_pkg::TIME_W-1:0];
      grant_q = {grant_q, g};
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      take_in = in_ch.valid && in_ch.ready;
      if (take_in) schedule_job(cur_req);
      if (!in_ch.valid || take_in) begin
        offer = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (job_req_q.size() > 0 &&
                     (!job_req_q[0].drain || grant_q.size() == 0)) begin
          cur_req = job_req_q.pop_front();
          offer   = 1'b1;
          send_gap = pick_gap();
          in_ch.func         <= cur_req.func;
          in_ch.server_index <= cur_req.sidx;
          in_ch.service_time <= cur_req.svc;
        end
        in_ch.valid <= offer;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (grant_q.size() == 0) begin
          fail_count++;
          $error("result with no dispatch pending: server %0d start %0d job %0d",
                 out_ch.chosen_server, out_ch.start_time, out_ch.job_number);
        end else begin
          want = grant_q.pop_front();
          if (out_ch.chosen_server !== want.server) begin
            fail_count++;
            $error("chosen_server: expected %0d, got %0d", want.server, out_ch.chosen_server);
          end
          if (out_ch.start_time !== want.start) begin
            fail_count++;
            $error("start_time: expected %0d, got %0d", want.start, out_ch.start_time);
          end
          if (out_ch.job_number !== want.job) begin
            fail_count++;
            $error("job_number: expected %0d, got %0d", want.job, out_ch.job_number);
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        stall_left  = LONG_HOLD;
      end
      if (stall_left == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_ch.ready <= ready_next;
    end
  end

  task automatic push_req(input logic [efsd_pkg::FUNC_W-1:0] f,
                          input logic [efsd_pkg::SIDX_W-1:0] s,
                          input logic [efsd_pkg::SVC_W-1:0] t);
    job_req_t r;
    r.func  = f;
    r.sidx  = s;
    r.svc   = t;
    r.drain = 1'b0;
    job_req_q = {job_req_q, r};
  endtask

  // random traffic, loads mostly aimed inside the active pool
  task automatic queue_random(input int n);
    job_req_t r;
    int       span;
    span = active_span();
    for (int k = 0; k < n; k++) begin
      r.drain = ($urandom_range(0, 49) == 0);
      r.func  = ($urandom_range(0, 9) < 7) ? efsd_pkg::FUNC_DISPATCH : efsd_pkg::FUNC_LOAD;
      if ($urandom_range(0, 3) == 0) begin
        r.sidx = efsd_pkg::SIDX_W'($urandom_range(0, MAX_SERVERS - 1));
      end else begin
        r.sidx = efsd_pkg::SIDX_W'($urandom_range(0, span - 1));
      end
      case ($urandom_range(0, 15))
        0:             r.svc = '0;
        1:             r.svc = 16'd1;
        2:             r.svc = '1;
        3, 4, 5, 6, 7: r.svc = efsd_pkg::SVC_W'($urandom_range(1, 20));
        default:       r.svc = efsd_pkg::SVC_W'($urandom);
      endcase
      job_req_q = {job_req_q, r};
    end
  endtask

  // all sent, all results in, then let a possible trailing load finish
  task automatic wait_idle();
    while (job_req_q.size() != 0 || in_ch.valid || grant_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pool(input logic [efsd_pkg::CFG_W-1:0] n);
    @(posedge clk);
    cfg_ch.data  <= n;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    pool_size = n;
  endtask

  // stimulus sequence
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.func         = efsd_pkg::FUNC_LOAD;
    in_ch.server_index = '0;
    in_ch.service_time = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;
    for (int i = 0; i < MAX_SERVERS; i++) begin
      free_at[i]  = '0;
      busy_for[i] = 16'd1;
    end
    jobs_issued = '0;
    pool_size   = 7'd1;
    pool_pl:
    begin
      pool_plan = '{7'd64, 7'd1, 7'd2, 7'd3, 7'd5, 7'd16,
                    7'd33, 7'd63, 7'd65, 7'd100, 7'd0, 7'd127};
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset state: one server, service time one
    repeat (3) push_req(efsd_pkg::FUNC_DISPATCH, '0, '0);
    wait_idle();

    // zero servers in use behaves as one
    write_pool(7'd0);
    push_req(efsd_pkg::FUNC_LOAD, 6'd0, 16'd3);
    repeat (2) push_req(efsd_pkg::FUNC_DISPATCH, 6'd63, 16'hFFFF);
    wait_idle();

    // oversized pool, field extremes, ties and a zero service time
    write_pool(7'd127);
    push_req(efsd_pkg::FUNC_LOAD, 6'd0, 16'hFFFF);
    push_req(efsd_pkg::FUNC_LOAD, 6'd63, 16'd1);
    push_req(efsd_pkg::FUNC_LOAD, 6'd5, 16'd0);
    push_req(efsd_pkg::FUNC_LOAD, 6'd42, 16'h5555);
    push_req(efsd_pkg::FUNC_LOAD, 6'd21, 16'hAAAA);
    repeat (10) push_req(efsd_pkg::FUNC_DISPATCH, '0, '0);
    push_req(efsd_pkg::FUNC_LOAD, 6'd5, 16'd2);
    repeat (3) push_req(efsd_pkg::FUNC_DISPATCH, 6'h2A, 16'h5555);
    wait_idle();

    // random phases over a range of pool sizes
    for (int p = 0; p < 12; p++) begin
      write_pool(pool_plan[p]);
      idle_on = (p % 3 != 0);
      // long receiver hold with the sender running flat out
      if (p == 0) hold_requests++;
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
